>>> hw/rtl/saoq_pkg.sv
// Package for the slot allocator with per-owner quota.
// Holds the item types, status and operation codes and the sequencer states.
// No dependencies.
package saoq_pkg;

  // Request operation codes
  typedef enum logic [0:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_QUOTA   = 2'd1,
    ST_NOFREE  = 2'd2,
    ST_NOTUSED = 2'd3
  } status_t;

  // Input item
  typedef struct packed {
    op_t         operation;
    logic [15:0] owner;
    logic [5:0]  slot;
  } in_item_t;

  // Result item
  typedef struct packed {
    status_t    status;
    logic [5:0] granted_slot;
    logic       any_active;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_ALLOC,
    S_ALLOC2,
    S_REL,
    S_REL2
  } state_t;

  localparam int QUOTA_W = 7;
  localparam logic [QUOTA_W-1:0] QUOTA_RESET = 7'd64;

endpackage

>>> hw/rtl/slot_allocator_owner_quota.sv
// Top level of the slot allocator: LIFO free list plus doubly linked active list.
// Depends on saoq_pkg; link, owner and busy stores are memories inside this module.
//
//   channel | ports                           | handshake
//   --------+---------------------------------+--------------------------------
//   input   | start, busy, in_data            | item taken when start && !busy
//   result  | out_valid, out_data             | one-cycle strobe, no back-pressure
//   config  | cfg_wr_en, cfg_wr_data          | quota written when cfg_wr_en
//
// The next item can be taken in the result strobe cycle. An allocate runs S_WALK (skipped
// when no slot is active) and S_CHECK, where it may be refused, then S_ALLOC and, if a slot
// was active, S_ALLOC2: the owner count walks the active list through the link memory, one
// node per cycle. Release of a slot in use runs S_REL and, if it has a predecessor,
// S_REL2; a slot not in use is refused in S_REL, a bad index at once.
// After reset a clearing pass rebuilds the free list; busy is high meanwhile.
// The result strobe lasts one cycle; the receiver cannot stall it.
module slot_allocator_owner_quota #(
  parameter int SLOTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  saoq_pkg::in_item_t          in_data,
  output logic                        out_valid,
  output saoq_pkg::out_item_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [saoq_pkg::QUOTA_W-1:0] cfg_wr_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NONE = LW'(SLOTS);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  // Memories
  logic [LW-1:0] next_mem  [SLOTS];
  logic [LW-1:0] prev_mem  [SLOTS];
  logic [15:0]   owner_mem [SLOTS];
  logic          busy_mem  [SLOTS];

  logic [SW-1:0] rd_addr;
  logic [LW-1:0] next_rd, prev_rd;
  logic [15:0]   owner_rd;
  logic          busy_rd;

  logic          nx_we, pv_we, ow_we, bz_we;
  logic [SW-1:0] nx_wa, pv_wa, ow_wa, bz_wa;
  logic [LW-1:0] nx_wd, pv_wd;
  logic [15:0]   ow_wd;
  logic          bz_wd;

  // Control and payload registers
  saoq_pkg::state_t    state_r, state_nxt;
  logic [SW-1:0]       clr_r, clr_nxt;
  logic [LW-1:0]       cnt_r, cnt_nxt;
  logic [LW-1:0]       free_top_r, free_top_nxt;
  logic [LW-1:0]       active_top_r, active_top_nxt;
  logic [saoq_pkg::QUOTA_W-1:0] quota_r;
  saoq_pkg::in_item_t  req_r, req_nxt;
  logic [LW-1:0]       link_a_r, link_a_nxt;
  logic [LW-1:0]       link_b_r, link_b_nxt;
  logic [SW-1:0]       pick_r, pick_nxt;
  logic                out_valid_r, out_valid_nxt;
  saoq_pkg::out_item_t out_data_r, out_data_nxt;

  logic [SW-1:0] req_slot;
  logic          in_slot_ok;

  assign req_slot   = SW'(req_r.slot);
  assign in_slot_ok = 32'(in_data.slot) < SLOTS;
  assign busy       = (state_r != saoq_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    next_rd <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    prev_rd <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ow_we) owner_mem[ow_wa] <= ow_wd;
    owner_rd <= owner_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (bz_we) busy_mem[bz_wa] <= bz_wd;
    busy_rd <= busy_mem[rd_addr];
  end

  // Hold state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= saoq_pkg::S_CLEAR;
      clr_r        <= '0;
      cnt_r        <= '0;
      free_top_r   <= '0;
      active_top_r <= NONE;
      quota_r      <= saoq_pkg::QUOTA_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      cnt_r        <= cnt_nxt;
      free_top_r   <= free_top_nxt;
      active_top_r <= active_top_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) quota_r <= cfg_wr_data;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    link_a_r   <= link_a_nxt;
    link_b_r   <= link_b_nxt;
    pick_r     <= pick_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sequencer: next state, memory accesses and result
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    free_top_nxt   = free_top_r;
    active_top_nxt = active_top_r;
    req_nxt        = req_r;
    link_a_nxt     = link_a_r;
    link_b_nxt     = link_b_r;
    pick_nxt       = pick_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    rd_addr        = '0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    ow_we = 1'b0; ow_wa = '0; ow_wd = '0;
    bz_we = 1'b0; bz_wa = '0; bz_wd = 1'b0;

    case (state_r)
      // Rebuild the free list in order and clear busy flags
      saoq_pkg::S_CLEAR: begin
        nx_we   = 1'b1;
        nx_wa   = clr_r;
        nx_wd   = (clr_r == LAST) ? NONE : LW'(clr_r) + LW'(1);
        bz_we   = 1'b1;
        bz_wa   = clr_r;
        bz_wd   = 1'b0;
        clr_nxt = clr_r + SW'(1);
        if (clr_r == LAST) state_nxt = saoq_pkg::S_IDLE;
      end

      // Take an item and start the first read, or refuse a bad release index at once
      saoq_pkg::S_IDLE: begin
        if (start) begin
          req_nxt = in_data;
          cnt_nxt = '0;
          if (in_data.operation == saoq_pkg::OP_ALLOC) begin
            rd_addr = active_top_r[SW-1:0];
            if (active_top_r == NONE) state_nxt = saoq_pkg::S_CHECK;
            else state_nxt = saoq_pkg::S_WALK;
          end else if (in_slot_ok) begin
            rd_addr   = SW'(in_data.slot);
            state_nxt = saoq_pkg::S_REL;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: saoq_pkg::ST_NOTUSED, granted_slot: 6'd0,
                              any_active: (active_top_r != NONE)};
          end
        end
      end

      // Count the owner's slots, one active node per cycle
      saoq_pkg::S_WALK: begin
        cnt_nxt = cnt_r + LW'(owner_rd == req_r.owner);
        rd_addr = next_rd[SW-1:0];
        if (next_rd == NONE) state_nxt = saoq_pkg::S_CHECK;
      end

      // Apply quota, then free-list check; read the next free link
      saoq_pkg::S_CHECK: begin
        if (32'(cnt_r) >= 32'(quota_r)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: saoq_pkg::ST_QUOTA, granted_slot: 6'd0,
                            any_active: (active_top_r != NONE)};
          state_nxt     = saoq_pkg::S_IDLE;
        end else if (free_top_r == NONE) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: saoq_pkg::ST_NOFREE, granted_slot: 6'd0,
                            any_active: (active_top_r != NONE)};
          state_nxt     = saoq_pkg::S_IDLE;
        end else begin
          rd_addr   = free_top_r[SW-1:0];
          state_nxt = saoq_pkg::S_ALLOC;
        end
      end

      // Pop the free head and push it at the active head
      saoq_pkg::S_ALLOC: begin
        pick_nxt       = free_top_r[SW-1:0];
        free_top_nxt   = next_rd;
        active_top_nxt = free_top_r;
        link_a_nxt     = active_top_r;
        nx_we = 1'b1; nx_wa = free_top_r[SW-1:0]; nx_wd = active_top_r;
        pv_we = 1'b1; pv_wa = free_top_r[SW-1:0]; pv_wd = NONE;
        ow_we = 1'b1; ow_wa = free_top_r[SW-1:0]; ow_wd = req_r.owner;
        bz_we = 1'b1; bz_wa = free_top_r[SW-1:0]; bz_wd = 1'b1;
        if (active_top_r != NONE) begin
          state_nxt = saoq_pkg::S_ALLOC2;
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: saoq_pkg::ST_OK,
                            granted_slot: 6'(free_top_r[SW-1:0]), any_active: 1'b1};
          state_nxt     = saoq_pkg::S_IDLE;
        end
      end

      // Link the old active head back to the new one
      saoq_pkg::S_ALLOC2: begin
        pv_we = 1'b1; pv_wa = link_a_r[SW-1:0]; pv_wd = LW'(pick_r);
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: saoq_pkg::ST_OK, granted_slot: 6'(pick_r),
                          any_active: 1'b1};
        state_nxt     = saoq_pkg::S_IDLE;
      end

      // Unlink the slot and push it on the free list, or refuse a slot not in use
      saoq_pkg::S_REL: begin
        if (!busy_rd) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: saoq_pkg::ST_NOTUSED, granted_slot: 6'd0,
                            any_active: (active_top_r != NONE)};
          state_nxt     = saoq_pkg::S_IDLE;
        end else begin
          link_a_nxt   = prev_rd;
          link_b_nxt   = next_rd;
          free_top_nxt = LW'(req_slot);
          nx_we = 1'b1; nx_wa = req_slot; nx_wd = free_top_r;
          bz_we = 1'b1; bz_wa = req_slot; bz_wd = 1'b0;
          if (next_rd != NONE) begin
            pv_we = 1'b1; pv_wa = next_rd[SW-1:0]; pv_wd = prev_rd;
          end
          if (prev_rd == NONE) begin
            active_top_nxt = next_rd;
            out_valid_nxt  = 1'b1;
            out_data_nxt   = '{status: saoq_pkg::ST_OK, granted_slot: 6'd0,
                               any_active: (next_rd != NONE)};
            state_nxt      = saoq_pkg::S_IDLE;
          end else begin
            state_nxt = saoq_pkg::S_REL2;
          end
        end
      end

      // Bridge the predecessor over the released slot
      saoq_pkg::S_REL2: begin
        nx_we = 1'b1; nx_wa = link_a_r[SW-1:0]; nx_wd = link_b_r;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: saoq_pkg::ST_OK, granted_slot: 6'd0,
                          any_active: 1'b1};
        state_nxt     = saoq_pkg::S_IDLE;
      end

      default: begin
        state_nxt = saoq_pkg::S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/saoq_checker.sv
// Port-level checker for the slot allocator and its bind to the top level.
// Depends on saoq_pkg; sees only the ports of slot_allocator_owner_quota.
module saoq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input saoq_pkg::out_item_t out_data
);

  // Clearing pass follows reset
  a_busy_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> busy)
    else $error("not busy right after reset");

  // An accepted item either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither started nor answered");

  // Refusals grant no slot
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != saoq_pkg::ST_OK) |-> (out_data.granted_slot == 6'd0))
    else $error("refused item carries a slot");

  // An empty pool means every slot is active
  a_nofree_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == saoq_pkg::ST_NOFREE) |-> out_data.any_active)
    else $error("no free slot reported with nothing active");

endmodule

bind slot_allocator_owner_quota saoq_checker u_saoq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
